### rtl/core/nfgw_pkg.sv
// shared types and constants of the nibble frame buffer glyph writer
package nfgw_pkg;

  localparam int FRAME_WIDTH   = 256;
  localparam int FRAME_HEIGHT  = 64;
  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_ROWS    = 7;

  localparam int ROW_BYTES   = (FRAME_WIDTH + 1) / 2;
  localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // port widths fixed by the command format
  localparam int CMD_W   = 2;
  localparam int X_W     = 9;
  localparam int Y_W     = 7;
  localparam int GRAY_W  = 4;
  localparam int GLYPH_W = 35;
  localparam int INDEX_W = 13;
  localparam int BYTE_W  = 8;

  // pixel coordinate widths, wide enough for position plus glyph offset and frame size
  localparam int PX_W = 11;
  localparam int PY_W = 9;

  localparam int COL_W = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
  localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  // command queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_GLYPH = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PIXEL,
    OP_READ
  } op_kind_t;

  // one unit of work for the back end
  typedef struct packed {
    op_kind_t            kind;
    logic [ADDR_W-1:0]   addr;
    logic                odd;   // low nibble when set
    logic [GRAY_W-1:0]   gray;
    logic                zero;  // read beyond the store returns zero
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

### rtl/core/nfgw_ram.sv
// generic single write port ram with registered read
module nfgw_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/nfgw_front.sv
// command front end: accepts commands, clips pixels, expands glyphs into pixel ops
module nfgw_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [nfgw_pkg::CMD_W-1:0]    command,
  input  logic [nfgw_pkg::X_W-1:0]      x_pos,
  input  logic [nfgw_pkg::Y_W-1:0]      y_pos,
  input  logic [nfgw_pkg::GRAY_W-1:0]   gray_level,
  input  logic [nfgw_pkg::GLYPH_W-1:0]  glyph_bits,
  input  logic [nfgw_pkg::INDEX_W-1:0]  read_index,
  input  nfgw_pkg::q_stat_t             q_stat,
  input  nfgw_pkg::back_stat_t          back_stat,
  output nfgw_pkg::q_push_t             q_push
);

  typedef enum logic {
    F_IDLE,
    F_GLYPH
  } fstate_t;

  fstate_t                        state;
  logic [nfgw_pkg::GLYPH_W-1:0]   g_bits;
  logic [nfgw_pkg::X_W-1:0]       g_x;
  logic [nfgw_pkg::Y_W-1:0]       g_y;
  logic [nfgw_pkg::GRAY_W-1:0]    g_gray;
  logic [nfgw_pkg::COL_W-1:0]     g_col;
  logic [nfgw_pkg::ROW_W-1:0]     g_row;

  logic                           accept;
  logic                           g_step;
  logic                           g_last;
  logic [nfgw_pkg::PX_W-1:0]      px;
  logic [nfgw_pkg::PY_W-1:0]      py;
  logic                           in_frame;
  logic [nfgw_pkg::ADDR_W-1:0]    pix_addr;

  assign busy   = (state == F_GLYPH) || q_stat.full || back_stat.clearing;
  assign accept = start && !busy;
  assign g_step = (state == F_GLYPH) && !q_stat.full;
  assign g_last = (g_col == nfgw_pkg::COL_W'(nfgw_pkg::GLYPH_COLUMNS - 1))
               && (g_row == nfgw_pkg::ROW_W'(nfgw_pkg::GLYPH_ROWS - 1));

  // pixel coordinates: from the glyph walk while a glyph is walked, from the ports otherwise
  always_comb begin
    if (state == F_GLYPH) begin
      px = nfgw_pkg::PX_W'(g_x) + nfgw_pkg::PX_W'(g_col);
      py = nfgw_pkg::PY_W'(g_y) + nfgw_pkg::PY_W'(g_row);
    end else begin
      px = nfgw_pkg::PX_W'(x_pos);
      py = nfgw_pkg::PY_W'(y_pos);
    end
  end

  assign in_frame = (px < nfgw_pkg::PX_W'(nfgw_pkg::FRAME_WIDTH))
                 && (py < nfgw_pkg::PY_W'(nfgw_pkg::FRAME_HEIGHT));
  assign pix_addr = nfgw_pkg::ADDR_W'(py) * nfgw_pkg::ADDR_W'(nfgw_pkg::ROW_BYTES)
                  + nfgw_pkg::ADDR_W'(px >> 1);

  always_comb begin
    q_push.valid   = 1'b0;
    q_push.op.kind = nfgw_pkg::OP_PIXEL;
    q_push.op.addr = pix_addr;
    q_push.op.odd  = px[0];
    q_push.op.gray = (state == F_GLYPH) ? g_gray : gray_level;
    q_push.op.zero = 1'b0;
    if (state == F_GLYPH) begin
      q_push.valid = g_step && g_bits[0] && in_frame;
    end else if (accept) begin
      unique case (nfgw_pkg::cmd_t'(command))
        nfgw_pkg::CMD_CLEAR: begin
          q_push.valid   = 1'b1;
          q_push.op.kind = nfgw_pkg::OP_CLEAR;
        end
        nfgw_pkg::CMD_PIXEL: begin
          q_push.valid = in_frame;
        end
        nfgw_pkg::CMD_GLYPH: begin
          q_push.valid = 1'b0;
        end
        nfgw_pkg::CMD_READ: begin
          q_push.valid   = 1'b1;
          q_push.op.kind = nfgw_pkg::OP_READ;
          q_push.op.addr = nfgw_pkg::ADDR_W'(read_index);
          q_push.op.zero = ({1'b0, read_index}
                            >= (nfgw_pkg::INDEX_W + 1)'(nfgw_pkg::STORE_BYTES));
        end
        default: begin
          q_push.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && (nfgw_pkg::cmd_t'(command) == nfgw_pkg::CMD_GLYPH)) begin
            state  <= F_GLYPH;
            g_bits <= glyph_bits;
            g_x    <= x_pos;
            g_y    <= y_pos;
            g_gray <= gray_level;
            g_col  <= '0;
            g_row  <= '0;
          end
        end
        F_GLYPH: begin
          if (g_step) begin
            g_bits <= g_bits >> 1;
            if (g_last) begin
              state <= F_IDLE;
            end else if (g_row == nfgw_pkg::ROW_W'(nfgw_pkg::GLYPH_ROWS - 1)) begin
              g_row <= '0;
              g_col <= g_col + 1'b1;
            end else begin
              g_row <= g_row + 1'b1;
            end
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/nfgw_queue.sv
// short fifo of work ops between front and back
module nfgw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  nfgw_pkg::q_push_t    q_push,
  input  logic                 pop,
  output nfgw_pkg::op_t        head,
  output nfgw_pkg::q_stat_t    q_stat
);

  nfgw_pkg::op_t                 entries [nfgw_pkg::QDEPTH];
  logic [nfgw_pkg::QPTR_W-1:0]   wr_ptr;
  logic [nfgw_pkg::QPTR_W-1:0]   rd_ptr;
  logic [nfgw_pkg::QCNT_W-1:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign q_stat.full  = (count == nfgw_pkg::QCNT_W'(nfgw_pkg::QDEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = q_push.valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/nfgw_back.sv
// back end: frame store ram, nibble read-modify-write, byte reads and clear sweep
module nfgw_back (
  input  logic                         clk,
  input  logic                         rst,
  input  nfgw_pkg::op_t                head,
  input  nfgw_pkg::q_stat_t            q_stat,
  output logic                         pop,
  output nfgw_pkg::back_stat_t         back_stat,
  output logic                         done,
  output logic [nfgw_pkg::BYTE_W-1:0]  read_byte
);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_MODIFY,
    B_RESULT
  } bstate_t;

  bstate_t                        state;
  nfgw_pkg::op_t                  cur;
  logic [nfgw_pkg::ADDR_W-1:0]    clr_ptr;

  logic                           we;
  logic [nfgw_pkg::ADDR_W-1:0]    waddr;
  logic [nfgw_pkg::BYTE_W-1:0]    wdata;
  logic [nfgw_pkg::BYTE_W-1:0]    rdata;

  nfgw_ram #(
    .DATA_W (nfgw_pkg::BYTE_W),
    .DEPTH  (nfgw_pkg::STORE_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (head.addr),
    .rdata (rdata)
  );

  assign back_stat.clearing = (state == B_CLEAR);

  always_comb begin
    we    = 1'b0;
    waddr = cur.addr;
    wdata = rdata;
    pop   = 1'b0;
    unique case (state)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_ptr;
        wdata = '0;
      end
      B_IDLE: begin
        pop = !q_stat.empty;
      end
      B_MODIFY: begin
        we = 1'b1;
        // even pixel in the high nibble, odd pixel in the low nibble
        if (cur.odd) begin
          wdata = {rdata[nfgw_pkg::BYTE_W-1:nfgw_pkg::GRAY_W], cur.gray};
        end else begin
          wdata = {cur.gray, rdata[nfgw_pkg::GRAY_W-1:0]};
        end
      end
      B_RESULT: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_CLEAR;
      clr_ptr <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == nfgw_pkg::ADDR_W'(nfgw_pkg::STORE_BYTES - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_stat.empty) begin
            cur <= head;
            unique case (head.kind)
              nfgw_pkg::OP_CLEAR: begin
                clr_ptr <= '0;
                state   <= B_CLEAR;
              end
              nfgw_pkg::OP_PIXEL: begin
                state <= B_MODIFY;
              end
              nfgw_pkg::OP_READ: begin
                state <= B_RESULT;
              end
              default: begin
                state <= B_IDLE;
              end
            endcase
          end
        end
        B_MODIFY: begin
          state <= B_IDLE;
        end
        B_RESULT: begin
          done      <= 1'b1;
          read_byte <= cur.zero ? '0 : rdata;
          state     <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/nibble_framebuffer_glyph_writer_top.sv
// top level of the packed 4-bit gray frame buffer with pixel and glyph drawing
//
// channel   | ports                                                  | beat taken when
// ----------+--------------------------------------------------------+-----------------------
// command   | command x_pos y_pos gray_level glyph_bits read_index   | start && !busy
// result    | read_byte                                              | done (one cycle only)
//
// ops: a pixel write is a read-modify-write on the frame ram, read at pop, written in B_MODIFY;
//   a read strobes done from B_RESULT after the back end pops it; a glyph walks its 35 pattern
//   bits one per cycle while the op queue is not full; clear zeroes all 8192 bytes
// reset: rst is synchronous; the back end then runs the same clearing sweep over all 8192 bytes
// stalls: busy is high while a glyph is walked, the op queue is full or a sweep runs;
//   the result side cannot stall, so done is a one-cycle strobe
module nibble_framebuffer_glyph_writer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [nfgw_pkg::CMD_W-1:0]    command,
  input  logic [nfgw_pkg::X_W-1:0]      x_pos,
  input  logic [nfgw_pkg::Y_W-1:0]      y_pos,
  input  logic [nfgw_pkg::GRAY_W-1:0]   gray_level,
  input  logic [nfgw_pkg::GLYPH_W-1:0]  glyph_bits,
  input  logic [nfgw_pkg::INDEX_W-1:0]  read_index,
  output logic                          done,
  output logic [nfgw_pkg::BYTE_W-1:0]   read_byte
);

  // front to queue: ops already clipped to the frame
  nfgw_pkg::q_push_t     q_push;
  // queue status to both ends, head and pop between queue and back
  nfgw_pkg::q_stat_t     q_stat;
  nfgw_pkg::op_t         q_head;
  logic                  q_pop;
  // back end status, the front holds off while a clear sweep runs
  nfgw_pkg::back_stat_t  back_stat;

  // front: classifies each command beat and expands glyphs into pixel ops
  nfgw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .gray_level (gray_level),
    .glyph_bits (glyph_bits),
    .read_index (read_index),
    .q_stat     (q_stat),
    .back_stat  (back_stat),
    .q_push     (q_push)
  );

  // short op queue lets the glyph walk run ahead of the ram work
  nfgw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (q_pop),
    .head   (q_head),
    .q_stat (q_stat)
  );

  // back: owns the frame ram and runs one op at a time in queue order
  nfgw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .back_stat (back_stat),
    .done      (done),
    .read_byte (read_byte)
  );

  // the back end returns to B_IDLE after every op, so result strobes never touch
  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two cycles in a row");

  // the clearing sweep after reset holds off new commands
  a_busy_after_reset : assert property (@(posedge clk)
    ($past(rst) && !rst) |-> busy)
    else $error("command port open right after reset");

  // the front never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !q_push.valid)
    else $error("op pushed into a full queue");

  // no read result comes out while the store is being cleared
  a_no_result_in_clear : assert property (@(posedge clk) disable iff (rst)
    done |-> !back_stat.clearing)
    else $error("read result during clear sweep");

endmodule
